// File: sv/rle_sprite_line_decoder_defines.svh
// Assertion macros for the sprite line decoder.
// Both expect clk and arst_n in scope.
`ifndef RLE_SPRITE_LINE_DECODER_DEFINES_SVH
`define RLE_SPRITE_LINE_DECODER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RSLD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked on every clock edge outside reset.
`define RSLD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// File: sv/rsld_pkg.sv
package rsld_pkg;

	typedef enum logic [7:0] {
		PH_BOUNDS  = 8'b0000_0001,
		PH_SIZE    = 8'b0000_0010,
		PH_LEFT    = 8'b0000_0100,
		PH_TOP     = 8'b0000_1000,
		PH_RAW     = 8'b0001_0000,
		PH_OPCODE  = 8'b0010_0000,
		PH_REPEAT  = 8'b0100_0000,
		PH_LITERAL = 8'b1000_0000
	} phase_t;

	localparam logic [1:0] KIND_BOUND = 2'd0;
	localparam logic [1:0] KIND_RUN   = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [1:0] LAST_BOUND = 2'd3;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  word_index;
		logic [7:0]  low_byte_hold;
		logic        high_byte_next;
		logic [14:0] line_length;
		logic        raw_mode;
		logic [15:0] cur_left;
		logic [15:0] cur_top;
		logic [15:0] pixel_count;
		logic [6:0]  literal_remaining;
		logic [6:0]  repeat_pending;
		logic        image_finished;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:             PH_BOUNDS,
		word_index:        2'd0,
		low_byte_hold:     8'd0,
		high_byte_next:    1'b0,
		line_length:       15'd0,
		raw_mode:          1'b0,
		cur_left:          16'd0,
		cur_top:           16'd0,
		pixel_count:       16'd0,
		literal_remaining: 7'd0,
		repeat_pending:    7'd0,
		image_finished:    1'b0
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  bound_select;
		logic [15:0] bound_value;
		logic [7:0]  pixel_value;
		logic [6:0]  run_length;
		logic [15:0] line_x;
		logic [15:0] line_y;
		logic [15:0] start_pos;
		logic        line_end;
	} result_t;

endpackage

// File: sv/rsld_parse.sv
// Next-state and result logic for one stream byte.
module rsld_parse (
	input  rsld_pkg::state_t  cur,
	input  logic [7:0]        data_byte,
	output rsld_pkg::state_t  nxt,
	output rsld_pkg::result_t res,
	output logic              fire
);

	logic [15:0] word;
	logic        word_done;
	logic        word_phase;
	logic [15:0] addend;
	logic [15:0] pc_sum;
	logic        reach;
	logic [6:0]  lit_m1;

	assign word      = {data_byte, cur.low_byte_hold};
	assign word_done = cur.high_byte_next;
	assign word_phase = (cur.phase == rsld_pkg::PH_BOUNDS) || (cur.phase == rsld_pkg::PH_SIZE)
		|| (cur.phase == rsld_pkg::PH_LEFT) || (cur.phase == rsld_pkg::PH_TOP);

	// one shared pixel counter adder: run length in repeat phase, else one
	assign addend = (cur.phase == rsld_pkg::PH_REPEAT) ? {9'd0, cur.repeat_pending} : 16'd1;
	assign pc_sum = cur.pixel_count + addend;
	assign reach  = pc_sum >= {1'b0, cur.line_length};
	assign lit_m1 = cur.literal_remaining - 7'd1;

	always_comb begin
		nxt  = cur;
		res  = '0;
		fire = 1'b0;
		if (!cur.image_finished) begin
			if (word_phase) begin
				if (!cur.high_byte_next) begin
					nxt.low_byte_hold  = data_byte;
					nxt.high_byte_next = 1'b1;
				end else begin
					nxt.high_byte_next = 1'b0;
				end
			end
			res.line_x = cur.cur_left;
			res.line_y = cur.cur_top;
			unique case (cur.phase)
				rsld_pkg::PH_BOUNDS: begin
					res.line_x = '0;
					res.line_y = '0;
					if (word_done) begin
						fire             = 1'b1;
						res.kind         = rsld_pkg::KIND_BOUND;
						res.bound_select = cur.word_index;
						res.bound_value  = word;
						if (cur.word_index == rsld_pkg::LAST_BOUND) begin
							nxt.word_index = 2'd0;
							nxt.phase      = rsld_pkg::PH_SIZE;
						end else begin
							nxt.word_index = cur.word_index + 2'd1;
						end
					end
				end
				rsld_pkg::PH_SIZE: begin
					res.line_x = '0;
					res.line_y = '0;
					if (word_done) begin
						if (word == 16'd0) begin
							nxt.image_finished = 1'b1;
							fire               = 1'b1;
							res.kind           = rsld_pkg::KIND_END;
						end else begin
							nxt.line_length = word[15:1];
							nxt.raw_mode    = ~word[0];
							nxt.phase       = rsld_pkg::PH_LEFT;
						end
					end
				end
				rsld_pkg::PH_LEFT: begin
					res.line_x = '0;
					res.line_y = '0;
					if (word_done) begin
						nxt.cur_left = word;
						nxt.phase    = rsld_pkg::PH_TOP;
					end
				end
				rsld_pkg::PH_TOP: begin
					res.line_y = word;
					if (word_done) begin
						nxt.cur_top     = word;
						nxt.pixel_count = 16'd0;
						if (cur.line_length == 15'd0) begin
							// empty line: a zero-length run that closes it
							fire         = 1'b1;
							res.kind     = rsld_pkg::KIND_RUN;
							res.line_end = 1'b1;
							nxt.phase    = rsld_pkg::PH_SIZE;
						end else begin
							nxt.phase = cur.raw_mode ? rsld_pkg::PH_RAW : rsld_pkg::PH_OPCODE;
						end
					end else begin
						res.line_x = '0;
						res.line_y = '0;
					end
				end
				rsld_pkg::PH_RAW: begin
					fire            = 1'b1;
					res.kind        = rsld_pkg::KIND_RUN;
					res.pixel_value = data_byte;
					res.run_length  = 7'd1;
					res.start_pos   = cur.pixel_count;
					res.line_end    = reach;
					nxt.pixel_count = pc_sum;
					if (reach) begin
						nxt.phase = rsld_pkg::PH_SIZE;
					end
				end
				rsld_pkg::PH_OPCODE: begin
					res.line_x = '0;
					res.line_y = '0;
					if (data_byte[0]) begin
						nxt.repeat_pending = data_byte[7:1];
						nxt.phase          = rsld_pkg::PH_REPEAT;
					end else begin
						nxt.literal_remaining = data_byte[7:1];
						if (data_byte[7:1] != 7'd0) begin
							nxt.phase = rsld_pkg::PH_LITERAL;
						end
					end
				end
				rsld_pkg::PH_REPEAT: begin
					nxt.phase = rsld_pkg::PH_OPCODE;
					if (cur.repeat_pending != 7'd0) begin
						fire               = 1'b1;
						res.kind           = rsld_pkg::KIND_RUN;
						res.pixel_value    = data_byte;
						res.run_length     = cur.repeat_pending;
						res.start_pos      = cur.pixel_count;
						res.line_end       = reach;
						nxt.pixel_count    = pc_sum;
						nxt.repeat_pending = 7'd0;
						if (reach) begin
							nxt.phase = rsld_pkg::PH_SIZE;
						end
					end else begin
						res.line_x = '0;
						res.line_y = '0;
					end
				end
				rsld_pkg::PH_LITERAL: begin
					fire                  = 1'b1;
					res.kind              = rsld_pkg::KIND_RUN;
					res.pixel_value       = data_byte;
					res.run_length        = 7'd1;
					res.start_pos         = cur.pixel_count;
					nxt.pixel_count       = pc_sum;
					nxt.literal_remaining = lit_m1;
					if (lit_m1 == 7'd0) begin
						// line closes only at the end of a literal group
						res.line_end = reach;
						nxt.phase    = reach ? rsld_pkg::PH_SIZE : rsld_pkg::PH_OPCODE;
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule

// File: sv/rle_sprite_line_decoder.sv
// A taken byte is held in the byte register; when it is consumed, any result it yields is registered.
// Throughput: one byte per cycle, held up only while a result waits under out_stall.
// The byte register and the result register each hold one entry; the parse state
// advances as a byte moves from the first into the second.
// Reset (arst_n low, asynchronous): both registers empty, parser expects the first
// bounds word, all counters and coordinates zero.
`include "rle_sprite_line_decoder_defines.svh"

module rle_sprite_line_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	// decoded results out
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [1:0]  bound_select,
	output logic [15:0] bound_value,
	output logic [7:0]  pixel_value,
	output logic [6:0]  run_length,
	output logic [15:0] line_x,
	output logic [15:0] line_y,
	output logic [15:0] start_pos,
	output logic        line_end
);

	// stage 1: registered byte
	logic              valid_s1;
	logic [7:0]        data_s1;

	// parser state, updated when the stage 1 byte is consumed
	rsld_pkg::state_t  state_q;
	rsld_pkg::state_t  state_nxt;
	rsld_pkg::result_t res_nxt;
	logic              fire;

	// result register
	logic              out_valid_q;
	rsld_pkg::result_t res_q;

	logic              advance;
	logic              consume;

	// the result slot frees when empty or when its transfer completes this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign consume  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	rsld_parse u_parse (
		.cur       (state_q),
		.data_byte (data_s1),
		.nxt       (state_nxt),
		.res       (res_nxt),
		.fire      (fire)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= rsld_pkg::STATE_RESET;
		end else begin
			if (!valid_s1 || advance) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && fire;
			end
			if (consume) begin
				state_q <= state_nxt;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!valid_s1 || advance) begin
			data_s1 <= data_byte;
		end
		if (consume && fire) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign bound_select = res_q.bound_select;
	assign bound_value  = res_q.bound_value;
	assign pixel_value  = res_q.pixel_value;
	assign run_length   = res_q.run_length;
	assign line_x       = res_q.line_x;
	assign line_y       = res_q.line_y;
	assign start_pos    = res_q.start_pos;
	assign line_end     = res_q.line_end;

	// a pending line-closing run leaves the parser waiting for a size word
	`RSLD_ASSERT_IMP(a_line_end_phase, out_valid_q && res_q.kind == rsld_pkg::KIND_RUN && res_q.line_end, state_q.phase == rsld_pkg::PH_SIZE, "line end without size phase")
	// once finished, only the end marker can still be pending
	`RSLD_ASSERT_IMP(a_finished_end, state_q.image_finished && out_valid_q, res_q.kind == rsld_pkg::KIND_END, "result after end of image")
	// a zero-length run only ever closes an empty line
	`RSLD_ASSERT_IMP(a_empty_run, out_valid_q && res_q.kind == rsld_pkg::KIND_RUN && res_q.run_length == 7'd0, res_q.line_end, "empty run not closing line")
	`RSLD_ASSERT_ALWAYS(a_phase_onehot, $onehot(state_q.phase), "parse phase not one-hot")

endmodule

// File: verif/rle_sprite_line_decoder_test.sv
module rle_sprite_line_decoder_test;

	localparam int unsigned IDLE_LIMIT   = 4000; // cycles with no transfer on either side
	localparam int unsigned DRAIN_CYCLES = 20;   // quiet time after the last result
	localparam int unsigned STREAM_BYTES = 1150; // least number of stream bytes queued before the end word

	// One entry of the byte stream: either a byte or a request to hold off
	// the sender until every predicted result has come back.
	typedef struct {
		bit         hold;
		logic [7:0] value;
	} stream_entry_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [1:0]  bound_select;
	logic [15:0] bound_value;
	logic [7:0]  pixel_value;
	logic [6:0]  run_length;
	logic [15:0] line_x;
	logic [15:0] line_y;
	logic [15:0] start_pos;
	logic        line_end;

	rle_sprite_line_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.bound_select (bound_select),
		.bound_value  (bound_value),
		.pixel_value  (pixel_value),
		.run_length   (run_length),
		.line_x       (line_x),
		.line_y       (line_y),
		.start_pos    (start_pos),
		.line_end     (line_end)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Decoder model state. Updated once per input transfer, in order.
	// ------------------------------------------------------------------
	rsld_pkg::phase_t dec_phase;
	logic [1:0]  bound_idx;
	logic [7:0]  lo_byte;      // low half of the word being assembled
	logic        hi_pending;   // next word byte is the high half
	logic [14:0] line_len;
	logic        raw_line;     // even size word: pixels come as raw bytes
	logic [15:0] line_left;
	logic [15:0] line_top;
	logic [15:0] pix_pos;      // pixels emitted so far on this line
	logic [6:0]  lit_left;     // literal bytes still owed by current opcode
	logic [6:0]  rep_count;    // repeat count waiting for its value byte
	logic        image_done;   // size word of zero seen; rest is ignored

	stream_entry_t     stream_q[$];
	rsld_pkg::result_t pending_records[$]; // predicted decoder results, oldest first
	int unsigned   stream_bytes = 0;   // bytes queued for the sender
	int unsigned   bytes_taken  = 0;   // bytes the decoder has accepted
	int unsigned   idle_cycles  = 0;
	int unsigned   failures     = 0;

	// Little-endian word assembly; returns 1 when the high byte completes it.
	function automatic bit take_half(input logic [7:0] b, output logic [15:0] w);
		w = '0;
		if (!hi_pending) begin
			lo_byte    = b;
			hi_pending = 1'b1;
			return 1'b0;
		end
		hi_pending = 1'b0;
		w = {b, lo_byte};
		return 1'b1;
	endfunction

	function automatic rsld_pkg::result_t make_run(input logic [7:0] value,
			input logic [6:0] len, input logic [15:0] first, input logic last);
		rsld_pkg::result_t r;
		r             = '0;
		r.kind        = rsld_pkg::KIND_RUN;
		r.pixel_value = value;
		r.run_length  = len;
		r.line_x      = line_left;
		r.line_y      = line_top;
		r.start_pos   = first;
		r.line_end    = last;
		return r;
	endfunction

	// Advances the model by one stream byte; returns 1 if the byte yields a result.
	function automatic bit decode_byte(input logic [7:0] b, output rsld_pkg::result_t r);
		logic [15:0] w;
		logic [15:0] first;
		logic        last;
		r = '0;
		if (image_done)
			return 1'b0;
		case (dec_phase)
			rsld_pkg::PH_BOUNDS: begin
				if (!take_half(b, w))
					return 1'b0;
				r.kind         = rsld_pkg::KIND_BOUND;
				r.bound_select = bound_idx;
				r.bound_value  = w;
				if (bound_idx == rsld_pkg::LAST_BOUND) begin
					bound_idx = '0;
					dec_phase = rsld_pkg::PH_SIZE;
				end else begin
					bound_idx = bound_idx + 2'd1;
				end
				return 1'b1;
			end
			rsld_pkg::PH_SIZE: begin
				if (!take_half(b, w))
					return 1'b0;
				if (w == 16'd0) begin
					image_done = 1'b1;
					r.kind     = rsld_pkg::KIND_END;
					return 1'b1;
				end
				line_len  = w[15:1];
				raw_line  = ~w[0];
				dec_phase = rsld_pkg::PH_LEFT;
				return 1'b0;
			end
			rsld_pkg::PH_LEFT: begin
				if (take_half(b, w)) begin
					line_left = w;
					dec_phase = rsld_pkg::PH_TOP;
				end
				return 1'b0;
			end
			rsld_pkg::PH_TOP: begin
				if (!take_half(b, w))
					return 1'b0;
				line_top = w;
				pix_pos  = '0;
				// a size of one declares a line with no pixels at all
				if (line_len == 15'd0) begin
					r         = make_run(8'd0, 7'd0, 16'd0, 1'b1);
					dec_phase = rsld_pkg::PH_SIZE;
					return 1'b1;
				end
				dec_phase = raw_line ? rsld_pkg::PH_RAW : rsld_pkg::PH_OPCODE;
				return 1'b0;
			end
			rsld_pkg::PH_RAW: begin
				first   = pix_pos;
				pix_pos = pix_pos + 16'd1;
				last    = (pix_pos >= {1'b0, line_len});
				r       = make_run(b, 7'd1, first, last);
				if (last)
					dec_phase = rsld_pkg::PH_SIZE;
				return 1'b1;
			end
			rsld_pkg::PH_OPCODE: begin
				if (b[0]) begin
					rep_count = b[7:1];
					dec_phase = rsld_pkg::PH_REPEAT;
				end else begin
					// literal count of zero stays in opcode phase
					lit_left = b[7:1];
					if (lit_left != 7'd0)
						dec_phase = rsld_pkg::PH_LITERAL;
				end
				return 1'b0;
			end
			rsld_pkg::PH_REPEAT: begin
				dec_phase = rsld_pkg::PH_OPCODE;
				if (rep_count == 7'd0)
					return 1'b0;
				first     = pix_pos;
				pix_pos   = pix_pos + {9'd0, rep_count};
				last      = (pix_pos >= {1'b0, line_len});
				r         = make_run(b, rep_count, first, last);
				rep_count = '0;
				if (last)
					dec_phase = rsld_pkg::PH_SIZE;
				return 1'b1;
			end
			rsld_pkg::PH_LITERAL: begin
				// the line may only close once the literal group is used up
				first    = pix_pos;
				pix_pos  = pix_pos + 16'd1;
				lit_left = lit_left - 7'd1;
				last     = 1'b0;
				if (lit_left == 7'd0) begin
					if (pix_pos >= {1'b0, line_len}) begin
						last      = 1'b1;
						dec_phase = rsld_pkg::PH_SIZE;
					end else begin
						dec_phase = rsld_pkg::PH_OPCODE;
					end
				end
				r = make_run(b, 7'd1, first, last);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void add_byte(input logic [7:0] v);
		stream_entry_t e;
		e.hold  = 1'b0;
		e.value = v;
		stream_q.push_back(e);
		stream_bytes++;
	endfunction

	function automatic void add_word(input logic [15:0] w);
		add_byte(w[7:0]);
		add_byte(w[15:8]);
	endfunction

	function automatic void add_hold();
		stream_entry_t e;
		e.hold  = 1'b1;
		e.value = '0;
		stream_q.push_back(e);
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// ------------------------------------------------------------------
	// Sender: bursts of random length separated by random gaps. A hold
	// entry parks the sender until every predicted result has drained.
	// ------------------------------------------------------------------
	int unsigned burst_left;
	int unsigned gap_left;
	bit          holding;
	int unsigned hold_cycles;

	always @(posedge clk or negedge arst_n) begin
		stream_entry_t next_entry;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			data_byte   <= 8'd0;
			burst_left  <= 0;
			gap_left    <= 0;
			holding     <= 1'b0;
			hold_cycles <= 0;
		end else if (!in_valid || !in_stall) begin
			if (holding) begin
				// wait before checking so the last transfer's prediction lands
				in_valid    <= 1'b0;
				hold_cycles <= hold_cycles + 1;
				if (hold_cycles >= 2 && pending_records.size() == 0)
					holding <= 1'b0;
			end else if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (stream_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (stream_q[0].hold) begin
				next_entry  = stream_q.pop_front();
				in_valid    <= 1'b0;
				holding     <= 1'b1;
				hold_cycles <= 0;
			end else begin
				next_entry = stream_q.pop_front();
				in_valid   <= 1'b1;
				data_byte  <= next_entry.value;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 48);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver stall pattern: switches among several styles over spans of
	// random length, including spans that never stall.
	// ------------------------------------------------------------------
	stall_mode_t stall_mode;
	int unsigned stall_span;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode <= STALL_NONE;
			stall_span <= 0;
		end else begin
			if (stall_span == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				stall_span <= $urandom_range(8, 160);
			end else begin
				stall_span <= stall_span - 1;
			end
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= ~out_stall;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each output transfer against the oldest prediction,
	// then runs the model on each input transfer of the same edge.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		rsld_pkg::result_t want;
		rsld_pkg::result_t got;
		if (!arst_n) begin
			dec_phase  = rsld_pkg::PH_BOUNDS;
			bound_idx  = '0;
			lo_byte    = '0;
			hi_pending = 1'b0;
			line_len   = '0;
			raw_line   = 1'b0;
			line_left  = '0;
			line_top   = '0;
			pix_pos    = '0;
			lit_left   = '0;
			rep_count  = '0;
			image_done = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_records.size() == 0) begin
					$error("unexpected result transfer: kind %0d", kind);
					failures++;
				end else begin
					want = pending_records.pop_front();
					got  = '{kind, bound_select, bound_value, pixel_value, run_length,
						line_x, line_y, start_pos, line_end};
					check_field("kind", want.kind, got.kind);
					check_field("bound_select", want.bound_select, got.bound_select);
					check_field("bound_value", want.bound_value, got.bound_value);
					check_field("pixel_value", want.pixel_value, got.pixel_value);
					check_field("run_length", want.run_length, got.run_length);
					check_field("line_x", want.line_x, got.line_x);
					check_field("line_y", want.line_y, got.line_y);
					check_field("start_pos", want.start_pos, got.start_pos);
					check_field("line_end", want.line_end, got.line_end);
				end
			end
			if (in_valid && !in_stall) begin
				bytes_taken++;
				if (decode_byte(data_byte, want))
					pending_records.push_back(want);
			end
		end
	end

	// Watchdog: counts cycles in which neither side transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles = 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run. The whole run is one image, since the
	// decoder ignores everything after the end word until reset.
	// ------------------------------------------------------------------
	initial begin
		int unsigned len;
		int unsigned cnt;
		int unsigned filled;
		int unsigned pick;
		bit          big_done;
		big_done = 1'b0;

		// bounds words at the extremes
		add_word(16'h0000);
		add_word(16'hFFFF);
		add_word(16'h8001);
		add_word(16'h7FFE);
		// line declared with no pixels
		add_word(16'h0001);
		add_word(16'hFFFF);
		add_word(16'h0000);
		// raw line of three pixels
		add_word(16'h0006);
		add_word(16'h0010);
		add_word(16'h0020);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'h5A);
		// opcode line of five pixels: repeat, zero repeat, zero literal,
		// then literals that run past the line length
		add_word(16'h000B);
		add_word(16'h0000);
		add_word(16'h0000);
		add_byte(8'h05);
		add_byte(8'h33);
		add_byte(8'h01);
		add_byte(8'hC3);
		add_byte(8'h00);
		add_byte(8'h04);
		add_byte(8'h11);
		add_byte(8'h22);
		add_byte(8'h06);
		add_byte(8'hA5);
		add_byte(8'h5A);
		add_byte(8'h96);
		// one-pixel line closed by the widest repeat
		add_word(16'h0003);
		add_word(16'hFFFF);
		add_word(16'hFFFF);
		add_byte(8'hFF);
		add_byte(8'hFF);
		add_hold();

		while (stream_bytes < STREAM_BYTES) begin
			if (!big_done && stream_bytes > 500) begin
				// longest line the size word allows, filled by maximal repeats
				big_done = 1'b1;
				add_word(16'hFFFF);
				add_word(pick_coord());
				add_word(pick_coord());
				filled = 0;
				while (filled < 32767) begin
					add_byte(8'hFF);
					add_byte(8'($urandom));
					filled += 127;
				end
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				add_word(16'h0001);
				add_word(pick_coord());
				add_word(pick_coord());
			end else if (pick < 45) begin
				len = $urandom_range(1, 16);
				add_word(16'(len << 1));
				add_word(pick_coord());
				add_word(pick_coord());
				repeat (len) add_byte(8'($urandom));
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
					: $urandom_range(1, 40);
				add_word(16'((len << 1) | 1));
				add_word(pick_coord());
				add_word(pick_coord());
				filled = 0;
				while (filled < len) begin
					pick = $urandom_range(0, 9);
					if (pick == 0) begin
						add_byte(8'h01);
						add_byte(8'($urandom));
					end else if (pick == 1) begin
						add_byte(8'h00);
					end else if (pick < 6) begin
						cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127)
							: $urandom_range(1, 12);
						add_byte(8'((cnt << 1) | 1));
						add_byte(8'($urandom));
						filled += cnt;
					end else begin
						cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 127)
							: $urandom_range(1, 8);
						add_byte(8'(cnt << 1));
						repeat (cnt) add_byte(8'($urandom));
						filled += cnt;
					end
				end
			end
			if ($urandom_range(0, 29) == 0)
				add_hold();
		end
		// end of image, then bytes that must be ignored
		add_word(16'h0000);
		repeat (6) add_byte(8'($urandom));

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (!(bytes_taken == stream_bytes && pending_records.size() == 0)
				&& idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		if (idle_cycles >= IDLE_LIMIT) begin
			$error("no transfer for %0d cycles, %0d bytes taken of %0d, %0d results outstanding",
				IDLE_LIMIT, bytes_taken, stream_bytes, pending_records.size());
			failures++;
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
		end
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/rsld_pkg.sv
sv/rsld_parse.sv
sv/rle_sprite_line_decoder.sv
verif/rle_sprite_line_decoder_test.sv
